FILE: rtl/core/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types and constants of the longest prefix match route table.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // default table depth
  localparam int unsigned ENTRIES_DEF = 64;

  // field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned IFACE_W = 4;

  // packed stream widths, padded to whole bytes
  localparam int unsigned IN_FIELDS_W  = 4 * ADDR_W + IFACE_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 3 * ADDR_W + IFACE_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // item kind carried in the input tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // result status carried in the output tuser
  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_HIT      = 2'd2,
    STATUS_MISS     = 2'd3
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // one stored route
  typedef struct packed {
    logic [IFACE_W-1:0] iface;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  gateway;
    logic [ADDR_W-1:0]  destination;
  } route_t;

  // controller to datapath
  typedef struct packed {
    logic latch;   // capture the accepted item, restart the scan
    logic rd_en;   // read the next table entry
    logic load;    // build the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_lookup;   // item on the input is a lookup
    logic count_zero;  // table holds no route
    logic last_idx;    // the read index is at the last held route
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

FILE: rtl/core/lpm_ctrl.sv
// ----------------------------------------------------------------------------
// lpm_ctrl
// Sequencer: accepts an item, walks the table for lookups and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module lpm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  lpm_pkg::sts_t sts_i,
  output lpm_pkg::cmd_t cmd_o
);

  lpm_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      lpm_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.latch = 1'b1;
          if (sts_i.in_lookup && !sts_i.count_zero) begin
            state_d = lpm_pkg::ST_SCAN;
          end else begin
            state_d = lpm_pkg::ST_FINISH;
          end
        end
      end
      lpm_pkg::ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.last_idx) begin
          state_d = lpm_pkg::ST_DRAIN;
        end
      end
      lpm_pkg::ST_DRAIN: begin
        // last read data is compared in this cycle
        state_d = lpm_pkg::ST_FINISH;
      end
      lpm_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = lpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lpm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/lpm_datapath.sv
// ----------------------------------------------------------------------------
// lpm_datapath
// Route memory, fill count, scan index, best-match tracking and the
// output register.
// ----------------------------------------------------------------------------
module lpm_datapath #(
  parameter int unsigned ENTRIES = lpm_pkg::ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [lpm_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [lpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic [1:0]                       m_axis_tuser_o,
  input  lpm_pkg::cmd_t                    cmd_i,
  output lpm_pkg::sts_t                    sts_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned AW   = lpm_pkg::ADDR_W;
  localparam int unsigned IW   = lpm_pkg::IFACE_W;

  // route memory
  lpm_pkg::route_t mem_q [ENTRIES];
  lpm_pkg::route_t rd_data_q;
  logic            rd_valid_q;

  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;

  // captured item
  logic            op_q;
  logic [AW-1:0]   addr_q;
  lpm_pkg::route_t ins_q;

  // best match so far
  logic            hit_q, hit_d;
  lpm_pkg::route_t best_q, best_d;

  // output register
  logic            m_valid_q, m_valid_d;
  logic [1:0]      m_status_q, m_status_d;
  lpm_pkg::route_t m_route_q, m_route_d;

  logic full;
  logic match;
  logic wr_en;

  assign full  = (count_q == CntW'(ENTRIES));
  assign wr_en = cmd_i.load && (op_q == lpm_pkg::OP_INSERT) && !full;

  // status toward the controller
  assign sts_o.in_lookup  = (s_axis_tuser_i == lpm_pkg::OP_LOOKUP);
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.last_idx   = (CntW'(rd_idx_q) == (count_q - CntW'(1)));
  assign sts_o.out_free   = !m_valid_q || m_axis_tready_i;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[IdxW-1:0]] <= ins_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  // capture of the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q              <= s_axis_tuser_i;
      addr_q            <= s_axis_tdata_i[AW-1:0];
      ins_q.destination <= s_axis_tdata_i[2*AW-1:AW];
      ins_q.gateway     <= s_axis_tdata_i[3*AW-1:2*AW];
      ins_q.mask        <= s_axis_tdata_i[4*AW-1:3*AW];
      ins_q.iface       <= s_axis_tdata_i[4*AW+IW-1:4*AW];
    end
  end

  // fill count and scan index
  always_comb begin
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    if (wr_en) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.latch) begin
      rd_idx_d = '0;
    end else if (cmd_i.rd_en) begin
      rd_idx_d = rd_idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      rd_idx_q   <= '0;
      rd_valid_q <= 1'b0;
      hit_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      count_q    <= count_d;
      rd_idx_q   <= rd_idx_d;
      rd_valid_q <= cmd_i.rd_en;
      hit_q      <= hit_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // compare one entry a cycle, keep the earliest of the greatest masks
  assign match = ((addr_q & rd_data_q.mask) == (rd_data_q.destination & rd_data_q.mask));

  always_comb begin
    hit_d  = hit_q;
    best_d = best_q;
    if (cmd_i.latch) begin
      hit_d = 1'b0;
    end else if (rd_valid_q && match && (!hit_q || (rd_data_q.mask > best_q.mask))) begin
      hit_d  = 1'b1;
      best_d = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  // result build into the output register
  always_comb begin
    m_valid_d  = m_valid_q;
    m_status_d = m_status_q;
    m_route_d  = m_route_q;
    if (cmd_i.load) begin
      m_valid_d = 1'b1;
      m_route_d = '0;
      if (op_q == lpm_pkg::OP_INSERT) begin
        m_status_d = full ? lpm_pkg::STATUS_FULL : lpm_pkg::STATUS_INSERTED;
      end else if (hit_q) begin
        m_status_d = lpm_pkg::STATUS_HIT;
        m_route_d  = best_q;
      end else begin
        m_status_d = lpm_pkg::STATUS_MISS;
      end
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    m_status_q <= m_status_d;
    m_route_q  <= m_route_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = lpm_pkg::OUT_DATA_W'({m_route_q.iface, m_route_q.mask,
                                                m_route_q.gateway, m_route_q.destination});

  // fill count never passes the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ENTRIES))
    else $error("route count above table depth");

  // reads stay inside the held routes
  a_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (CntW'(rd_idx_q) < count_q))
    else $error("read of an unheld table entry");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!m_valid_q || m_axis_tready_i))
    else $error("output register overwritten");

  // a miss carries all-zero route fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_status_q == lpm_pkg::STATUS_MISS)) |-> (m_route_q == '0))
    else $error("miss with nonzero route fields");

endmodule

FILE: rtl/core/longest_prefix_match_table_core.sv
// ----------------------------------------------------------------------------
// longest_prefix_match_table_core
// IPv4 route table: inserts append routes, lookups return the matching
// route with the greatest mask, earliest route on a tie.
//
//   channel  dir  tdata                                 tuser
//   s_axis   in   lookup_address, route_destination,    operation
//                 route_gateway, route_mask,
//                 route_interface
//   m_axis   out  match_destination, match_gateway,     status
//                 match_mask, match_interface
//
// An insert goes from the accept step to the finish step; a lookup runs the
// scan, which reads one route a cycle from the single memory port, then the
// drain and finish steps, and skips the scan on an empty table.
// Reset clears the route count; table contents need no clearing.
// The result sits in an output register, so a new item is accepted while
// a result waits; a stalled output holds the block in its last step.
// ----------------------------------------------------------------------------
module longest_prefix_match_table_core #(
  parameter int unsigned ENTRIES = lpm_pkg::ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata from bit 0: lookup_address, route_destination, route_gateway,
  // route_mask, route_interface, zero pad
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [lpm_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: operation
  input  logic                           s_axis_tuser_i,
  // tdata from bit 0: match_destination, match_gateway, match_mask,
  // match_interface, zero pad
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [lpm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: status
  output logic [1:0]                     m_axis_tuser_o
);

  lpm_pkg::cmd_t cmd;
  lpm_pkg::sts_t sts;

  // sequencer
  lpm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // table and result datapath
  lpm_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
